@@ design/ctrks_pkg.sv @@
package ctrks_pkg;

	localparam int MAX_BLOCK_BYTES = 16;
	localparam int REG_BYTES = 16;

	typedef logic [REG_BYTES-1:0][7:0] block_t;

	typedef enum logic [2:0] {
		ST_BYTE_OUT   = 3'd0,
		ST_KEY_NEEDED = 3'd1,
		ST_REPEAT     = 3'd2,
		ST_BAD_CFG    = 3'd3,
		ST_RESTARTED  = 3'd4,
		ST_UNEXPECTED = 3'd5
	} status_t;

	localparam logic [1:0] CMD_DATA = 2'd0;
	localparam logic [1:0] CMD_KEY  = 2'd1;

	localparam logic [2:0] CFG_BLOCK_BYTES   = 3'd0;
	localparam logic [2:0] CFG_PREFIX_BYTES  = 3'd1;
	localparam logic [2:0] CFG_COUNTER_BYTES = 3'd2;
	localparam logic [2:0] CFG_LITTLE_ENDIAN = 3'd3;
	localparam logic [2:0] CFG_INIT_HI       = 3'd4;
	localparam logic [2:0] CFG_INIT_LO       = 3'd5;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  data_byte;
		logic [63:0] keystream_hi;
		logic [63:0] keystream_lo;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  data_out;
		logic [63:0] counter_hi;
		logic [63:0] counter_lo;
	} out_item_t;

	typedef struct packed {
		logic [4:0]  block_bytes;
		logic [3:0]  prefix_bytes;
		logic [4:0]  counter_bytes;
		logic        little_endian;
		logic [63:0] init_hi;
		logic [63:0] init_lo;
		logic        ok;
	} cfg_t;

endpackage

@@ design/ctr_mode_keystream_xor_unit.sv @@
// Counter-mode keystream unit for an external block cipher. Every transaction on the input
// channel yields exactly one result transaction. Data bytes (command 0) are XORed with the
// current keystream block; when it is used up the byte is held, the counter block is sent
// out with status 1 for encryption, and the counter field is advanced. The encrypted block
// comes back with command 1, which releases the held byte. Command 2 or 3 restarts from the
// initial block and clears the sticky repeated-keystream error. Configuration is written
// through cfg_write/cfg_index/cfg_data; the user must do so only while the unit is idle, which
// the block does not enforce. A restart loads a new initial block into the counter. Each item
// goes through the input register, then one pass of counter increment, compare and byte select
// into the result register; one transaction per cycle is sustained while the output side does not stall.
module ctr_mode_keystream_xor_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ctrks_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ctrks_pkg::out_item_t out_item
);

	ctrks_pkg::cfg_t     cfg;
	ctrks_pkg::in_item_t item_s1;
	logic                valid_s1;
	logic                take;

	ctrks_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ctrks_inreg u_inreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ctrks_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

`ifndef SYNTHESIS
	a_counter_only_on_request: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ctrks_pkg::ST_KEY_NEEDED
		|-> out_item.counter_hi == 64'd0 && out_item.counter_lo == 64'd0)
		else $error("counter block on a result that does not request keystream");

	a_data_only_on_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ctrks_pkg::ST_BYTE_OUT |-> out_item.data_out == 8'd0)
		else $error("data byte on a result that carries no byte");

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while the result register is empty");

	a_take_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid)
		else $error("accepted transaction produced no result");
`endif

endmodule

@@ design/ctrks_cfg.sv @@
module ctrks_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	output ctrks_pkg::cfg_t     cfg
);

	logic [4:0]  block_bytes_q;
	logic [3:0]  prefix_bytes_q;
	logic [4:0]  counter_bytes_q;
	logic        little_endian_q;
	logic [63:0] init_hi_q;
	logic [63:0] init_lo_q;
	logic [5:0]  field_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q   <= 5'd16;
			prefix_bytes_q  <= 4'd0;
			counter_bytes_q <= 5'd16;
			little_endian_q <= 1'b0;
			init_hi_q       <= '0;
			init_lo_q       <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ctrks_pkg::CFG_BLOCK_BYTES:   block_bytes_q   <= cfg_data[4:0];
				ctrks_pkg::CFG_PREFIX_BYTES:  prefix_bytes_q  <= cfg_data[3:0];
				ctrks_pkg::CFG_COUNTER_BYTES: counter_bytes_q <= cfg_data[4:0];
				ctrks_pkg::CFG_LITTLE_ENDIAN: little_endian_q <= cfg_data[0];
				ctrks_pkg::CFG_INIT_HI:       init_hi_q       <= cfg_data;
				ctrks_pkg::CFG_INIT_LO:       init_lo_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign field_end = {2'b00, prefix_bytes_q} + {1'b0, counter_bytes_q};

	always_comb begin
		cfg.block_bytes   = block_bytes_q;
		cfg.prefix_bytes  = prefix_bytes_q;
		cfg.counter_bytes = counter_bytes_q;
		cfg.little_endian = little_endian_q;
		cfg.init_hi       = init_hi_q;
		cfg.init_lo       = init_lo_q;
		cfg.ok = (block_bytes_q != 5'd0)
			&& (block_bytes_q <= 5'(ctrks_pkg::MAX_BLOCK_BYTES))
			&& (counter_bytes_q != 5'd0)
			&& (field_end <= {1'b0, block_bytes_q});
	end

endmodule

@@ design/ctrks_inreg.sv @@
module ctrks_inreg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ctrks_pkg::in_item_t  in_item,
	input  logic                 take,
	output logic                 valid_s1,
	output ctrks_pkg::in_item_t  item_s1
);

	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ design/ctrks_core.sv @@
module ctrks_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrks_pkg::cfg_t      cfg,
	input  logic                 valid_s1,
	input  ctrks_pkg::in_item_t  item_s1,
	output logic                 take,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ctrks_pkg::out_item_t out_item
);

	localparam int NB = ctrks_pkg::REG_BYTES;

	function automatic ctrks_pkg::block_t unpack_block(input logic [63:0] hi,
			input logic [63:0] lo);
		ctrks_pkg::block_t b;
		for (int i = 0; i < 8; i++) begin
			b[i]     = hi[63-8*i -: 8];
			b[8 + i] = lo[63-8*i -: 8];
		end
		return b;
	endfunction

	ctrks_pkg::block_t ctr_q, ks_q, ctr_d, ks_d, adv, init_blk, ks_in, emit;
	logic [63:0] emit_hi, emit_lo;
	logic [4:0] used_q, used_d;
	logic [7:0] held_byte_q, held_byte_d;
	logic       held_q, held_d, rep_q, rep_d;
	logic       out_valid_q;
	ctrks_pkg::out_item_t res;

	logic [NB-1:0] in_field, pass, carry;
	logic [5:0]    field_end;
	logic          wrap;

	assign take = valid_s1 && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	// masked counter increment with byte carry chain
	always_comb begin
		field_end = {2'b00, cfg.prefix_bytes} + {1'b0, cfg.counter_bytes};
		for (int i = 0; i < NB; i++) begin
			in_field[i] = (5'(i) >= {1'b0, cfg.prefix_bytes}) && (6'(i) < field_end);
			pass[i]     = !in_field[i] || (ctr_q[i] == 8'hFF);
		end
		for (int i = 0; i < NB; i++) begin
			if (cfg.little_endian) begin
				carry[i] = &(pass | (NB'('1) << i));
			end else begin
				carry[i] = &(pass | ~(NB'('1) << (i + 1)));
			end
			adv[i] = (in_field[i] && carry[i]) ? ctr_q[i] + 8'd1 : ctr_q[i];
		end
	end

	always_comb begin
		init_blk = unpack_block(cfg.init_hi, cfg.init_lo);
		ks_in    = unpack_block(item_s1.keystream_hi, item_s1.keystream_lo);
		wrap     = 1'b1;
		emit_hi  = '0;
		emit_lo  = '0;
		for (int i = 0; i < NB; i++) begin
			if (5'(i) < cfg.block_bytes && adv[i] != init_blk[i]) begin
				wrap = 1'b0;
			end
			emit[i] = (5'(i) < cfg.block_bytes) ? ctr_q[i] : 8'd0;
		end
		// byte 0 goes out most significant
		for (int i = 0; i < 8; i++) begin
			emit_hi[63-8*i -: 8] = emit[i];
			emit_lo[63-8*i -: 8] = emit[8 + i];
		end
	end

	always_comb begin
		ctr_d       = ctr_q;
		ks_d        = ks_q;
		used_d      = used_q;
		held_byte_d = held_byte_q;
		held_d      = held_q;
		rep_d       = rep_q;
		res         = '0;
		priority if (item_s1.command[1]) begin
			ctr_d       = init_blk;
			used_d      = cfg.block_bytes;
			held_byte_d = 8'd0;
			held_d      = 1'b0;
			rep_d       = 1'b0;
			res.status  = ctrks_pkg::ST_RESTARTED;
		end else if (!cfg.ok) begin
			res.status = ctrks_pkg::ST_BAD_CFG;
		end else if (item_s1.command == ctrks_pkg::CMD_KEY) begin
			if (!held_q) begin
				res.status = ctrks_pkg::ST_UNEXPECTED;
			end else begin
				ks_d         = ks_in;
				res.status   = ctrks_pkg::ST_BYTE_OUT;
				res.data_out = held_byte_q ^ ks_in[0];
				used_d       = 5'd1;
				held_d       = 1'b0;
				held_byte_d  = 8'd0;
			end
		end else if (rep_q) begin
			res.status = ctrks_pkg::ST_REPEAT;
		end else if (held_q) begin
			res.status = ctrks_pkg::ST_KEY_NEEDED;
		end else if (used_q < cfg.block_bytes) begin
			res.status   = ctrks_pkg::ST_BYTE_OUT;
			res.data_out = item_s1.data_byte ^ ks_q[used_q[3:0]];
			used_d       = used_q + 5'd1;
		end else begin
			ctr_d = adv;
			if (wrap) begin
				rep_d      = 1'b1;
				res.status = ctrks_pkg::ST_REPEAT;
			end else begin
				held_byte_d    = item_s1.data_byte;
				held_d         = 1'b1;
				res.status     = ctrks_pkg::ST_KEY_NEEDED;
				res.counter_hi = emit_hi;
				res.counter_lo = emit_lo;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q       <= '0;
			ks_q        <= '0;
			used_q      <= 5'd16;
			held_byte_q <= 8'd0;
			held_q      <= 1'b0;
			rep_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				ctr_q       <= ctr_d;
				ks_q        <= ks_d;
				used_q      <= used_d;
				held_byte_q <= held_byte_d;
				held_q      <= held_d;
				rep_q       <= rep_d;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_item <= res;
		end
	end

endmodule

@@ bench/tb_ctr_mode_keystream_xor_unit.sv @@
module tb_ctr_mode_keystream_xor_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ctrks_pkg::*;

	localparam logic [1:0] CMD_RESTART     = 2'd2;
	localparam logic [1:0] CMD_RESTART_ALT = 2'd3;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = CFG_BLOCK_BYTES;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;

	ctr_mode_keystream_xor_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// shadow copy of the configuration
	logic [4:0]  blk_len = 5'd16;
	logic [3:0]  ctr_offset = '0;
	logic [4:0]  ctr_len = 5'd16;
	logic        ctr_le = 1'b0;
	logic [63:0] init_hi = '0;
	logic [63:0] init_lo = '0;

	// shadow copy of the keystream state
	block_t      counter_blk;
	block_t      key_blk;
	logic [4:0]  key_used;
	logic [7:0]  held_byte;
	logic        held_valid;
	logic        repeat_err;

	in_item_t    pending_items[$];
	out_item_t   expected_results[$];
	int          items_queued = 0;
	int          results_taken = 0;
	int          errors = 0;
	int          in_idle_pct = 0;
	int          out_stall_pct = 0;
	logic        hold_go = 1'b0;
	logic        hold_done;
	int          hold_left;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic block_t to_block(logic [63:0] hi, logic [63:0] lo);
		block_t b;
		for (int i = 0; i < 8; i++) begin
			b[i] = hi[63-8*i -: 8];
			b[8+i] = lo[63-8*i -: 8];
		end
		return b;
	endfunction

	function automatic logic [63:0] pack_half(block_t b, int base, int n);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < 8; i++)
			v = {v[55:0], (base + i < n) ? b[base+i] : 8'h00};
		return v;
	endfunction

	function automatic void restart_state();
		counter_blk = to_block(init_hi, init_lo);
		key_used = blk_len;
		held_byte = '0;
		held_valid = 1'b0;
		repeat_err = 1'b0;
	endfunction

	function automatic out_item_t predict_keystream_result(in_item_t it);
		out_item_t   r;
		int          n;
		int          pos;
		block_t      init_blk;
		logic [63:0] hi;
		logic [63:0] lo;
		logic        same;
		r = '0;
		n = int'(blk_len);
		if (it.command == CMD_RESTART || it.command == CMD_RESTART_ALT) begin
			restart_state();
			r.status = ST_RESTARTED;
			return r;
		end
		if (n < 1 || n > MAX_BLOCK_BYTES || ctr_len == 0 ||
				int'(ctr_offset) + int'(ctr_len) > n) begin
			r.status = ST_BAD_CFG;
			return r;
		end
		if (it.command == CMD_KEY) begin
			if (!held_valid) begin
				r.status = ST_UNEXPECTED;
				return r;
			end
			key_blk = to_block(it.keystream_hi, it.keystream_lo);
			r.status = ST_BYTE_OUT;
			r.data_out = held_byte ^ key_blk[0];
			key_used = 5'd1;
			held_valid = 1'b0;
			held_byte = '0;
			return r;
		end
		if (repeat_err) begin
			r.status = ST_REPEAT;
			return r;
		end
		if (held_valid) begin
			r.status = ST_KEY_NEEDED;
			return r;
		end
		if (int'(key_used) < n) begin
			r.status = ST_BYTE_OUT;
			r.data_out = it.data_byte ^ key_blk[key_used[3:0]];
			key_used = key_used + 5'd1;
			return r;
		end
		// keystream used up: hand out the counter block, then step the counter field
		hi = pack_half(counter_blk, 0, n);
		lo = pack_half(counter_blk, 8, n);
		for (int i = 0; i < int'(ctr_len); i++) begin
			pos = ctr_le ? int'(ctr_offset) + i : int'(ctr_offset) + int'(ctr_len) - 1 - i;
			pos = pos & 15;
			counter_blk[pos] = counter_blk[pos] + 8'd1;
			if (counter_blk[pos] != 8'd0)
				break;
		end
		init_blk = to_block(init_hi, init_lo);
		same = 1'b1;
		for (int i = 0; i < n; i++)
			if (init_blk[i] != counter_blk[i])
				same = 1'b0;
		if (same) begin
			repeat_err = 1'b1;
			r.status = ST_REPEAT;
			return r;
		end
		held_byte = it.data_byte;
		held_valid = 1'b1;
		r.status = ST_KEY_NEEDED;
		r.counter_hi = hi;
		r.counter_lo = lo;
		return r;
	endfunction

	function automatic void queue_item(logic [1:0] cmd, logic [7:0] b, logic [63:0] khi,
			logic [63:0] klo);
		in_item_t it;
		it.command = cmd;
		it.data_byte = b;
		it.keystream_hi = khi;
		it.keystream_lo = klo;
		pending_items.push_back(it);
		items_queued++;
	endfunction

	function automatic void queue_rand(logic [1:0] cmd);
		queue_item(cmd, 8'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
	endfunction

	// mostly whole keystream rounds: a byte that asks for keystream, the delivery,
	// then the rest of the block; the remainder is stray bytes, deliveries and restarts
	function automatic void queue_traffic(int count);
		int target;
		int n;
		int pick;
		target = items_queued + count;
		n = (blk_len >= 1 && blk_len <= MAX_BLOCK_BYTES) ? int'(blk_len) : 4;
		while (items_queued < target) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				queue_rand(CMD_DATA);
				queue_rand(CMD_KEY);
				repeat (n - 1) queue_rand(CMD_DATA);
			end else if (pick < 88) begin
				repeat ($urandom_range(3, 1)) queue_rand(CMD_DATA);
			end else if (pick < 94) begin
				queue_rand(CMD_KEY);
			end else if (pick < 98) begin
				queue_rand(CMD_RESTART);
			end else begin
				queue_rand(CMD_RESTART_ALT);
			end
		end
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_BLOCK_BYTES: blk_len = val[4:0];
			CFG_PREFIX_BYTES: ctr_offset = val[3:0];
			CFG_COUNTER_BYTES: ctr_len = val[4:0];
			CFG_LITTLE_ENDIAN: ctr_le = val[0];
			CFG_INIT_HI: init_hi = val;
			CFG_INIT_LO: init_lo = val;
			default: ;
		endcase
	endtask

	task automatic set_config(int blk, int pre, int len, logic le, logic [63:0] hi,
			logic [63:0] lo);
		write_reg(CFG_BLOCK_BYTES, 64'(blk));
		write_reg(CFG_PREFIX_BYTES, 64'(pre));
		write_reg(CFG_COUNTER_BYTES, 64'(len));
		write_reg(CFG_LITTLE_ENDIAN, 64'(le));
		write_reg(CFG_INIT_HI, hi);
		write_reg(CFG_INIT_LO, lo);
	endtask

	task automatic set_random_config();
		int blk;
		int len;
		blk = $urandom_range(16, 1);
		len = $urandom_range(blk, 1);
		set_config(blk, $urandom_range(blk - len, 0), len, 1'($urandom),
			{$urandom, $urandom}, {$urandom, $urandom});
	endtask

	task automatic drain();
		while (results_taken < items_queued)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(predict_keystream_result(in_item));
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
					in_valid <= 1'b1;
					in_item <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, with one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < out_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_taken++;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected transaction status %0d data %02h counter %016h %016h",
					$time, out_item.status, out_item.data_out, out_item.counter_hi,
					out_item.counter_lo);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (out_item.status !== want.status || out_item.data_out !== want.data_out ||
						out_item.counter_hi !== want.counter_hi ||
						out_item.counter_lo !== want.counter_lo) begin
					$display("%0t: mismatch expected status %0d data %02h counter %016h %016h",
						$time, want.status, want.data_out, want.counter_hi, want.counter_lo);
					$display("%0t:          actual status %0d data %02h counter %016h %016h",
						$time, out_item.status, out_item.data_out, out_item.counter_hi,
						out_item.counter_lo);
					errors++;
				end
			end
		end
	end

	initial begin
		int unsigned cycle_cnt;
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("ctr_mode_keystream_xor_unit verification failed");
		$finish;
	end

	initial begin
		int blk;
		int len;
		int pre_min;
		key_blk = '0;
		restart_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset configuration: full block, zero initial block
		queue_item(CMD_KEY, 8'hA5, '1, '1);
		queue_item(CMD_DATA, 8'h00, '0, '0);
		queue_item(CMD_DATA, 8'hFF, '1, '1);
		queue_item(CMD_KEY, 8'h00, 64'hFF00_FF00_0123_4567, 64'h89AB_CDEF_0000_FFFF);
		queue_item(CMD_DATA, 8'hFF, '0, '0);
		queue_item(CMD_KEY, 8'h5A, '0, '0);
		queue_item(CMD_RESTART_ALT, 8'hFF, '1, '1);
		queue_item(CMD_DATA, 8'h3C, '0, '0);
		queue_item(CMD_RESTART, 8'h00, '0, '0);
		drain();

		// counter field runs past the block
		set_config(16, 8, 16, 1'b0, '0, '0);
		queue_item(CMD_DATA, 8'h81, '0, '0);
		queue_item(CMD_KEY, 8'h7E, '1, '1);
		queue_item(CMD_RESTART, 8'h00, '0, '0);
		drain();

		// carry across the field, then an initial block one step ahead forces a repeat
		set_config(4, 1, 2, 1'b1, 64'h11FF_FF22_0BAD_F00D, '1);
		queue_item(CMD_RESTART, 8'h00, '0, '0);
		queue_item(CMD_DATA, 8'h44, '0, '0);
		drain();
		write_reg(CFG_INIT_HI, 64'h1101_0022_DEAD_BEEF);
		queue_item(CMD_KEY, 8'h00, 64'h0102_0304_0506_0708, '0);
		repeat (3) queue_rand(CMD_DATA);
		queue_rand(CMD_DATA);
		queue_rand(CMD_DATA);
		queue_rand(CMD_KEY);
		queue_item(CMD_RESTART, 8'h00, '0, '0);
		drain();

		// full block, big-endian, zero initial block, no idling
		set_config(16, 0, 16, 1'b0, '0, '0);
		in_idle_pct = 0;
		out_stall_pct = 0;
		queue_rand(CMD_RESTART);
		queue_traffic(100);
		drain();

		// one-byte counter at the last position, all-ones initial block
		set_config(16, 15, 1, 1'b1, '1, '1);
		in_idle_pct = 46;
		out_stall_pct = 0;
		queue_rand(CMD_RESTART);
		queue_traffic(100);
		drain();

		// long output hold-off while the input keeps offering
		set_random_config();
		in_idle_pct = 0;
		out_stall_pct = 0;
		hold_go = 1'b1;
		queue_rand(CMD_RESTART);
		queue_traffic(100);
		drain();

		set_random_config();
		in_idle_pct = 17;
		out_stall_pct = 17;
		queue_rand(CMD_RESTART);
		queue_traffic(100);
		drain();

		// one-byte block: the counter wraps back to the initial block after 256 rounds
		set_config(1, 0, 1, 1'b0, {$urandom, $urandom}, {$urandom, $urandom});
		in_idle_pct = 0;
		out_stall_pct = 46;
		queue_rand(CMD_RESTART);
		repeat (256) begin
			queue_rand(CMD_DATA);
			queue_rand(CMD_KEY);
		end
		queue_rand(CMD_DATA);
		queue_rand(CMD_RESTART);
		drain();

		// inconsistent field placement
		blk = $urandom_range(8, 1);
		len = $urandom_range(16, 1);
		pre_min = (blk - len + 1 > 0) ? blk - len + 1 : 0;
		set_config(blk, $urandom_range(15, pre_min), len, 1'($urandom),
			{$urandom, $urandom}, {$urandom, $urandom});
		in_idle_pct = 0;
		out_stall_pct = 0;
		queue_traffic(30);
		drain();

		// new settings without a restart: the counter block carries over
		set_random_config();
		in_idle_pct = 0;
		out_stall_pct = 46;
		queue_traffic(100);
		drain();

		set_config(8, 0, 8, 1'b1, '1, '1);
		in_idle_pct = 17;
		out_stall_pct = 17;
		queue_rand(CMD_RESTART);
		queue_traffic(100);
		drain();

		if (errors == 0)
			$display("ctr_mode_keystream_xor_unit verification clean");
		else
			$display("ctr_mode_keystream_xor_unit verification failed");
		$finish;
	end

endmodule
